// File: design/mode_string_parser_top_assert.svh
// Assertion macros for the mode string parser.
// Each check samples on the rising edge of clock and is off while reset is high.
`ifndef MODE_STRING_PARSER_TOP_ASSERT_SVH
`define MODE_STRING_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MSP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mode string parser check failed");
`define MSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mode string parser check failed");
`else
`define MSP_ASSERT_IMPL(lbl, ante, cons)
`define MSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/msp_pkg.sv
package msp_pkg;

   localparam logic [11:0] PERM_ALL     = 12'o7777;
   localparam logic [11:0] UMASK_RESET  = 12'd18;
   localparam logic [15:0] MODE_ERROR   = 16'hFFFF;
   localparam logic [3:0]  TYPE_DIR     = 4'o4;

   // who letters
   localparam logic [11:0] WHO_ALL      = 12'o6777;
   localparam logic [11:0] WHO_GROUP    = 12'o2070;
   localparam logic [11:0] WHO_OTHER    = 12'o0007;
   localparam logic [11:0] WHO_USER     = 12'o4700;

   // perm letters
   localparam logic [11:0] BITS_R       = 12'o0444;
   localparam logic [11:0] BITS_W       = 12'o0222;
   localparam logic [11:0] BITS_X       = 12'o0111;
   localparam logic [11:0] BITS_SETID   = 12'o6000;
   localparam logic [11:0] BITS_STICKY  = 12'o1000;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_BIG_X = 8'h58;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_T     = 8'h74;

   typedef struct packed {
      logic [7:0]  ch;
      logic        start_req;
      logic [15:0] file_mode;
   } item_type;

   typedef struct packed {
      logic [15:0] new_mode;
      logic        error;
   } result_type;

endpackage

// File: design/msp_parse.sv
module msp_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  msp_pkg::item_type   item,
   input  logic [11:0]         umask,
   output msp_pkg::result_type result
);

   typedef enum logic [1:0] {PH_WHO, PH_COPY, PH_PERM, PH_DONE} phase_type;
   typedef enum logic [1:0] {OP_NONE, OP_ADD, OP_SUB, OP_SET} op_type;

   phase_type   phase_ff, phase_in;
   op_type      kind_ff, kind_in;
   logic [15:0] mode_ff, mode_in;
   logic [11:0] who_ff, who_in;
   logic [11:0] clr_ff, clr_in;
   logic [11:0] perm_ff, perm_in;
   logic [11:0] oct_ff, oct_in;
   logic        allo_ff, allo_in;
   logic        err_ff, err_in;

   always_comb begin
      logic [14:0] oct_sum;
      logic [2:0]  grp;
      logic [11:0] sel;

      phase_in = phase_ff;
      kind_in  = kind_ff;
      mode_in  = mode_ff;
      who_in   = who_ff;
      clr_in   = clr_ff;
      perm_in  = perm_ff;
      oct_in   = oct_ff;
      allo_in  = allo_ff;
      err_in   = err_ff;
      oct_sum  = '0;
      grp      = '0;
      sel      = '0;

      // start of a string: fresh parse on the sampled mode
      if (item.start_req) begin
         phase_in = PH_WHO;
         kind_in  = OP_NONE;
         mode_in  = item.file_mode;
         who_in   = '0;
         clr_in   = '0;
         perm_in  = '0;
         oct_in   = '0;
         allo_in  = 1'b1;
         err_in   = 1'b0;
      end

      // octal accumulation, saturating
      if (item.ch != msp_pkg::CH_NUL) begin
         if (item.ch inside {[msp_pkg::CH_0:msp_pkg::CH_7]}) begin
            oct_sum = {oct_in, item.ch[2:0]};
            oct_in  = (oct_sum[14:12] != 3'b000) ? msp_pkg::PERM_ALL : oct_sum[11:0];
         end else begin
            allo_in = 1'b0;
         end
      end

      case (phase_in)
         PH_WHO: begin
            case (item.ch)
               msp_pkg::CH_A: who_in = who_in | msp_pkg::WHO_ALL;
               msp_pkg::CH_G: who_in = who_in | msp_pkg::WHO_GROUP;
               msp_pkg::CH_O: who_in = who_in | msp_pkg::WHO_OTHER;
               msp_pkg::CH_U: who_in = who_in | msp_pkg::WHO_USER;
               default: begin
                  if (who_in != '0) begin
                     clr_in = who_in;
                  end else begin
                     clr_in = msp_pkg::PERM_ALL;
                     who_in = ~umask & msp_pkg::PERM_ALL;
                  end
                  perm_in  = '0;
                  phase_in = PH_COPY;
                  case (item.ch)
                     msp_pkg::CH_PLUS:  kind_in = OP_ADD;
                     msp_pkg::CH_MINUS: kind_in = OP_SUB;
                     msp_pkg::CH_EQ:    kind_in = OP_SET;
                     default: begin
                        perm_in  = perm_ff;
                        err_in   = 1'b1;
                        phase_in = PH_DONE;
                     end
                  endcase
               end
            endcase
         end
         PH_COPY, PH_PERM: begin
            if (phase_in == PH_COPY && (item.ch == msp_pkg::CH_G ||
                item.ch == msp_pkg::CH_O || item.ch == msp_pkg::CH_U)) begin
               // copy another class's current rwx
               if (item.ch == msp_pkg::CH_G) begin
                  grp = mode_in[5:3];
               end else if (item.ch == msp_pkg::CH_O) begin
                  grp = mode_in[2:0];
               end else begin
                  grp = mode_in[8:6];
               end
               if (grp[2]) perm_in = perm_in | msp_pkg::BITS_R;
               if (grp[1]) perm_in = perm_in | msp_pkg::BITS_W;
               if (grp[0]) perm_in = perm_in | msp_pkg::BITS_X;
            end else begin
               phase_in = PH_PERM;
               case (item.ch)
                  msp_pkg::CH_BIG_X: begin
                     if (mode_in[15:12] == msp_pkg::TYPE_DIR ||
                         (mode_in[11:0] & msp_pkg::BITS_X) != '0) begin
                        perm_in = perm_in | msp_pkg::BITS_X;
                     end
                  end
                  msp_pkg::CH_R: perm_in = perm_in | msp_pkg::BITS_R;
                  msp_pkg::CH_S: perm_in = perm_in | msp_pkg::BITS_SETID;
                  msp_pkg::CH_T: perm_in = perm_in | msp_pkg::BITS_STICKY;
                  msp_pkg::CH_W: perm_in = perm_in | msp_pkg::BITS_W;
                  msp_pkg::CH_X: perm_in = perm_in | msp_pkg::BITS_X;
                  default: begin
                     // clause ends: apply it to the running mode
                     sel = perm_in & who_in;
                     case (kind_in)
                        OP_ADD:  mode_in[11:0] = mode_in[11:0] | sel;
                        OP_SUB:  mode_in[11:0] = mode_in[11:0] & ~sel;
                        OP_SET:  mode_in[11:0] = (mode_in[11:0] & ~clr_in) | sel;
                        default: mode_in[11:0] = mode_in[11:0];
                     endcase
                     if (item.ch == msp_pkg::CH_COMMA) begin
                        who_in   = '0;
                        phase_in = PH_WHO;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
               endcase
            end
         end
         default: phase_in = PH_DONE;
      endcase

      if (allo_in) begin
         result.new_mode = {4'b0000, oct_in};
         result.error    = 1'b0;
      end else if (err_in) begin
         result.new_mode = msp_pkg::MODE_ERROR;
         result.error    = 1'b1;
      end else begin
         result.new_mode = mode_in;
         result.error    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && item.ch == msp_pkg::CH_NUL)) begin
         phase_ff <= PH_WHO;
         kind_ff  <= OP_NONE;
         mode_ff  <= '0;
         who_ff   <= '0;
         clr_ff   <= '0;
         perm_ff  <= '0;
         oct_ff   <= '0;
         allo_ff  <= 1'b1;
         err_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         mode_ff  <= mode_in;
         who_ff   <= who_in;
         clr_ff   <= clr_in;
         perm_ff  <= perm_in;
         oct_ff   <= oct_in;
         allo_ff  <= allo_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: design/mode_string_parser_top.sv
// Mode string parser: applies a chmod-style mode string to a 16-bit file mode.
// Input channel (req_*): one character per item; req_start_req marks the first
// character of a string and samples req_file_mode; a NUL character ends it.
// Result channel (rsp_*): one item per NUL, carrying the new mode and an error
// flag (mode reads all ones on error). Other characters produce no result.
// csr_wr_en/csr_wr_data write the 12-bit umask; write only while idle.
// An accepted item is evaluated from the input register, and a NUL's result is
// registered in the output register, which drives rsp_*.
// Throughput: one item per cycle while no NUL waits behind a stalled result.
// A stalled result holds in the output register; the input register keeps
// taking non-NUL characters, and only a NUL behind a stalled result waits.
// Reset clears both valid flags and the parse state; umask returns to 022.
`include "mode_string_parser_top_assert.svh"

module mode_string_parser_top (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_start_req,
   input  logic [15:0] req_file_mode,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_new_mode,
   output logic        rsp_error,
   // umask register
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   logic                s1_valid_ff, s1_valid_in;
   msp_pkg::item_type   s1_item_ff;
   logic                out_valid_ff, out_valid_in;
   msp_pkg::result_type out_ff;
   logic [11:0]         umask_ff;

   msp_pkg::result_type step_result;
   logic                s1_nul;
   logic                s1_fire;
   logic                req_take;
   logic                rsp_take;

   // A NUL in the input register needs a free output slot; anything else
   // retires unconditionally.
   assign s1_nul    = (s1_item_ff.ch == msp_pkg::CH_NUL);
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!s1_nul || !out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_fire && s1_nul) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         umask_ff     <= msp_pkg::UMASK_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            umask_ff <= csr_wr_data;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= '{ch: req_ch, start_req: req_start_req, file_mode: req_file_mode};
      end
      if (s1_fire && s1_nul) begin
         out_ff <= step_result;
      end
   end

   msp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_item_ff),
      .umask  (umask_ff),
      .result (step_result)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_new_mode = out_ff.new_mode;
   assign rsp_error    = out_ff.error;

   `MSP_ASSERT_IMPL(a_err_mode, rsp_valid && rsp_error, rsp_new_mode == msp_pkg::MODE_ERROR)
   `MSP_ASSERT_IMPL(a_stall_full, req_stall, s1_valid_ff && s1_nul && out_valid_ff)
   `MSP_ASSERT_NEXT(a_result_out, s1_fire && s1_nul, rsp_valid)
   `MSP_ASSERT_NEXT(a_hold_result, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_new_mode))

endmodule
